>>> src/bfr_pkg.sv
package bfr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h81;

  // bytes in one payload word
  localparam int unsigned BYTES_PER_WORD = 2;

  // frame status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_ACCEPTED = 2'd3;

  // message type for an id that is not in the table
  localparam logic [2:0] MT_NONE  = 3'd0;
  localparam logic [2:0] MT_OTHER = 3'd7;

  localparam int unsigned NUM_KNOWN = 7;
  localparam logic [15:0] KNOWN_IDS [NUM_KNOWN] = '{
    16'd3000, 16'd3001, 16'd3011, 16'd3002, 16'd3003, 16'd3006, 16'd2200
  };

  // receive phases; other codes behave like the first sync hunt
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_ID_LO   = 4'd2,
    PH_ID_HI   = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_RES_LO  = 4'd6,
    PH_RES_HI  = 4'd7,
    PH_CK_LO   = 4'd8,
    PH_CK_HI   = 4'd9,
    PH_PAYLOAD = 4'd10,
    PH_STATUS  = 4'd12
  } phase_e;

  // header verdict handed to the top level
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] mtype;
  } hdr_res_t;

  // one result item
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [8:0]  payload_index;
    logic [1:0]  frame_status;
    logic [2:0]  msg_type;
    logic [15:0] msg_id;
    logic [15:0] msg_words;
  } res_t;

  // table lookup of a message id, first match wins
  function automatic logic [2:0] msg_type_of(logic [15:0] id);
    logic [2:0] t;
    t = MT_OTHER;
    for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
      if (id == KNOWN_IDS[k]) begin
        t = 3'(k);
      end
    end
    return t;
  endfunction

endpackage

>>> src/bfr_if.sv
// byte request channel
interface bfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// result request channel
interface bfr_res_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_data;
  logic [8:0]  payload_index;
  logic [1:0]  frame_status;
  logic [2:0]  msg_type;
  logic [15:0] msg_id;
  logic [15:0] msg_words;

  modport source (
    output valid, output payload_valid, output payload_data, output payload_index,
    output frame_status, output msg_type, output msg_id, output msg_words,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_data, input payload_index,
    input frame_status, input msg_type, input msg_id, input msg_words,
    output ready
  );
endinterface

>>> src/bfr_hdr_check.sv
module bfr_hdr_check (
  input  logic [7:0]        sync_first_i,
  input  logic [7:0]        sync_second_i,
  input  logic [15:0]       id_i,
  input  logic [15:0]       len_i,
  input  logic [15:0]       rsv_i,
  input  logic [15:0]       ck_i,
  output bfr_pkg::hdr_res_t verdict_o
);
  import bfr_pkg::*;

  logic [15:0] sum;
  logic [15:0] total;
  logic        sum_ok;
  logic [2:0]  mtype;

  // header words plus checksum wrap to zero on a good header
  always_comb begin
    sum    = {sync_second_i, sync_first_i} + id_i + len_i + rsv_i;
    total  = sum + ck_i;
    sum_ok = (total == 16'd0);
    mtype  = msg_type_of(id_i);
  end

  // status and type for the status byte
  always_comb begin
    if (!sum_ok) begin
      verdict_o.status = ST_BAD_SUM;
      verdict_o.mtype  = MT_OTHER;
    end else begin
      verdict_o.mtype  = mtype;
      verdict_o.status = (mtype == MT_OTHER) ? ST_UNKNOWN : ST_ACCEPTED;
    end
  end

endmodule

>>> src/binary_frame_receiver_top.sv
// Binary frame receiver.
// Bytes of a serial stream come in on rx_ch, one byte per request, and every
// accepted byte gives exactly one result request on res_ch. The block hunts
// for the two sync bytes (registers 0 and 1 of the write port), captures the
// little-endian id, length, reserved and checksum words, then marks
// 2*length payload bytes with payload_valid and their buffer index, which
// wraps at BUF_BYTES. The byte after the payload is passed with no marks, and
// the byte after that carries the frame status and message type.
// Every result shows the current id and length words.
// A result appears in the cycle after its byte is accepted.
// One byte per cycle unless stalled; each byte passes the phase machine
// and the header sum between the byte handshake and the result register.
// A stalled receiver holds the result register; a new byte is still taken in
// the cycle the held result leaves (rx_ch.ready follows res_ch.ready).
// Reset clears the phase machine, header words and counters and loads the
// sync registers with 0xFF and 0x81; no result is pending after reset.
module binary_frame_receiver_top #(
  parameter int unsigned BUF_BYTES = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i,
  bfr_rx_if.sink                          rx_ch,
  bfr_res_if.source                       res_ch
);
  import bfr_pkg::*;

  localparam int unsigned PosW = $clog2(BUF_BYTES);
  localparam int unsigned CntW = 17;

  logic [7:0]      sync_first_q, sync_second_q;
  phase_e          phase_q, phase_d;
  logic [15:0]     id_q, id_d, len_q, len_d, rsv_q, rsv_d, ck_q, ck_d;
  logic [CntW-1:0] cnt_q, cnt_d, limit;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW:0]   pos_inc;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;
  hdr_res_t        verdict;
  logic            accept;
  logic [7:0]      b;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // header check on the captured words
  bfr_hdr_check u_hdr_check (
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .id_i          (id_q),
    .len_i         (len_q),
    .rsv_i         (rsv_q),
    .ck_i          (ck_q),
    .verdict_o     (verdict)
  );

  assign rx_ch.ready = !res_valid_q || res_ch.ready;
  assign accept      = rx_ch.valid && rx_ch.ready;
  assign b           = rx_ch.rx_byte;
  assign limit       = CntW'({len_q, 1'b0});
  assign pos_inc     = {1'b0, pos_q} + (PosW+1)'(1);

  // phase machine and result for the accepted byte
  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    rsv_d   = rsv_q;
    ck_d    = ck_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    res_d   = '0;
    unique case (phase_q)
      PH_SYNC2:  phase_d = (b == sync_second_q) ? PH_ID_LO : PH_SYNC1;
      PH_ID_LO: begin
        id_d    = {id_q[15:8], b};
        phase_d = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_d    = {b, id_q[7:0]};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {len_q[15:8], b};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {b, len_q[7:0]};
        cnt_d   = '0;
        pos_d   = '0;
        phase_d = PH_RES_LO;
      end
      PH_RES_LO: begin
        rsv_d   = {rsv_q[15:8], b};
        phase_d = PH_RES_HI;
      end
      PH_RES_HI: begin
        rsv_d   = {b, rsv_q[7:0]};
        phase_d = PH_CK_LO;
      end
      PH_CK_LO: begin
        ck_d    = {ck_q[15:8], b};
        phase_d = PH_CK_HI;
      end
      PH_CK_HI: begin
        ck_d    = {b, ck_q[7:0]};
        phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (cnt_q < limit) begin
          res_d.payload_valid = 1'b1;
          res_d.payload_data  = b;
          res_d.payload_index = 9'(pos_q);
          pos_d = (pos_inc >= (PosW+1)'(BUF_BYTES)) ? '0 : pos_inc[PosW-1:0];
          cnt_d = cnt_q + CntW'(1);
        end else begin
          // trailing byte is dropped
          cnt_d   = '0;
          pos_d   = '0;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        res_d.frame_status = verdict.status;
        res_d.msg_type     = verdict.mtype;
        phase_d            = PH_SYNC1;
      end
      default: phase_d = (b == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
    endcase
    res_d.msg_id    = id_d;
    res_d.msg_words = len_d;
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      id_q    <= '0;
      len_q   <= '0;
      rsv_q   <= '0;
      ck_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      rsv_q   <= rsv_d;
      ck_q    <= ck_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (accept) begin
      res_valid_d = 1'b1;
    end else if (res_ch.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_ch.valid         = res_valid_q;
  assign res_ch.payload_valid = res_q.payload_valid;
  assign res_ch.payload_data  = res_q.payload_data;
  assign res_ch.payload_index = res_q.payload_index;
  assign res_ch.frame_status  = res_q.frame_status;
  assign res_ch.msg_type      = res_q.msg_type;
  assign res_ch.msg_id        = res_q.msg_id;
  assign res_ch.msg_words     = res_q.msg_words;

`ifndef SYNTHESIS
  // a payload byte below the count limit leaves as a marked payload result
  a_payload_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_PAYLOAD && cnt_q < limit
    |=> res_ch.valid && res_ch.payload_valid && res_ch.frame_status == ST_NONE)
    else $error("payload byte not marked");

  // the status byte always returns to the sync hunt
  a_status_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_STATUS |=> phase_q == PH_SYNC1 && res_ch.frame_status != ST_NONE)
    else $error("status byte did not close the frame");

  // the buffer position stays inside the buffer
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PosW+1)'(pos_q) < (PosW+1)'(BUF_BYTES))
    else $error("buffer position out of range");

  // the payload count never passes the frame length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> cnt_q <= limit)
    else $error("payload count beyond frame length");
`endif

endmodule

>>> tb/tb_binary_frame_receiver_top.sv
module tb_binary_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfr_pkg::*;

  localparam int unsigned BUF_BYTES       = 512;
  localparam int unsigned PHASE_BYTES     = 340;
  localparam int unsigned HOLD_CYCLES     = 250;
  localparam int unsigned HOLD_EVERY      = 3000;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam int unsigned LONG_TAIL_BYTES = 48;

  // decodes the byte stream the same way the block should and keeps the
  // results that are still owed
  class frame_checker;
    logic [7:0]  sync_lo;
    logic [7:0]  sync_hi;
    phase_e      rx_phase;
    logic [15:0] id_w;
    logic [15:0] len_w;
    logic [15:0] resv_w;
    logic [15:0] ck_w;
    logic [16:0] pay_count;
    logic [8:0]  buf_pos;
    res_t        expected_res[$];
    int unsigned errors;

    function new();
      sync_lo   = SYNC_FIRST_RST;
      sync_hi   = SYNC_SECOND_RST;
      rx_phase  = PH_SYNC1;
      id_w      = '0;
      len_w     = '0;
      resv_w    = '0;
      ck_w      = '0;
      pay_count = '0;
      buf_pos   = '0;
      errors    = 0;
    endfunction

    function void set_sync(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_SYNC_FIRST) begin
        sync_lo = val;
      end else if (idx == CFG_SYNC_SECOND) begin
        sync_hi = val;
      end
    endfunction

    // one accepted byte gives exactly one result
    function void decode_byte(logic [7:0] b);
      res_t        r;
      logic [15:0] hsum;
      r = '0;
      case (rx_phase)
        PH_SYNC2: begin
          rx_phase = (b == sync_hi) ? PH_ID_LO : PH_SYNC1;
        end
        PH_ID_LO: begin
          id_w[7:0] = b;
          rx_phase  = PH_ID_HI;
        end
        PH_ID_HI: begin
          id_w[15:8] = b;
          rx_phase   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_w[7:0] = b;
          rx_phase   = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_w[15:8] = b;
          pay_count   = '0;
          buf_pos     = '0;
          rx_phase    = PH_RES_LO;
        end
        PH_RES_LO: begin
          resv_w[7:0] = b;
          rx_phase    = PH_RES_HI;
        end
        PH_RES_HI: begin
          resv_w[15:8] = b;
          rx_phase     = PH_CK_LO;
        end
        PH_CK_LO: begin
          ck_w[7:0] = b;
          rx_phase  = PH_CK_HI;
        end
        PH_CK_HI: begin
          ck_w[15:8] = b;
          rx_phase   = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          // full-width count; the byte after the last payload byte is dropped
          if (pay_count < 17'(BYTES_PER_WORD * len_w)) begin
            r.payload_valid = 1'b1;
            r.payload_data  = b;
            r.payload_index = buf_pos;
            buf_pos   = (buf_pos == 9'(BUF_BYTES - 1)) ? '0 : buf_pos + 9'd1;
            pay_count = pay_count + 17'd1;
          end else begin
            pay_count = '0;
            buf_pos   = '0;
            rx_phase  = PH_STATUS;
          end
        end
        PH_STATUS: begin
          // byte value ignored; header sum plus checksum must wrap to zero
          rx_phase   = PH_SYNC1;
          hsum       = {sync_hi, sync_lo} + id_w + len_w + resv_w;
          r.msg_type = MT_OTHER;
          if (16'(hsum + ck_w) != 16'h0000) begin
            r.frame_status = ST_BAD_SUM;
          end else begin
            for (int k = 0; k < NUM_KNOWN; k++) begin
              if (KNOWN_IDS[k] == id_w) begin
                r.msg_type = 3'(k);
                break;
              end
            end
            r.frame_status = (r.msg_type == MT_OTHER) ? ST_UNKNOWN : ST_ACCEPTED;
          end
        end
        default: begin
          rx_phase = (b == sync_lo) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
      r.msg_id    = id_w;
      r.msg_words = len_w;
      expected_res.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
      end
    endfunction

    function void check_result(res_t act);
      res_t exp_r;
      if (expected_res.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, act);
        end
        return;
      end
      exp_r = expected_res.pop_front();
      check_field("payload_valid", exp_r.payload_valid, act.payload_valid);
      check_field("payload_data", exp_r.payload_data, act.payload_data);
      check_field("payload_index", exp_r.payload_index, act.payload_index);
      check_field("frame_status", exp_r.frame_status, act.frame_status);
      check_field("msg_type", exp_r.msg_type, act.msg_type);
      check_field("msg_id", exp_r.msg_id, act.msg_id);
      check_field("msg_words", exp_r.msg_words, act.msg_words);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_wdata_i;

  bfr_rx_if  rx_ch ();
  bfr_res_if res_ch ();

  frame_checker sb = new();

  int unsigned burst_left     = 0;
  int unsigned bytes_sent     = 0;
  int unsigned frames_sent    = 0;
  int unsigned results_seen   = 0;
  bit          sender_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  binary_frame_receiver_top #(
    .BUF_BYTES(BUF_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_ch      (rx_ch),
    .res_ch     (res_ch)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one byte request, with a random gap at the start of each burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4 || !sender_gaps_on) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    sb.decode_byte(b);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic pause_sender();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // sync pair and the four header words under the sync values in force
  task automatic send_header(input logic [15:0] id, input logic [15:0] len,
                             input logic [15:0] resv, input bit good);
    logic [15:0] ck;
    ck = 16'h0000 - ({sb.sync_hi, sb.sync_lo} + id + len + resv);
    if (!good) begin
      ck = ck ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_byte(sb.sync_lo);
    send_byte(sb.sync_hi);
    send_byte(id[7:0]);
    send_byte(id[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(resv[7:0]);
    send_byte(resv[15:8]);
    send_byte(ck[7:0]);
    send_byte(ck[15:8]);
  endtask

  // whole frame under the sync values in force
  task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                            input logic [15:0] resv, input bit good,
                            input logic [7:0] drop_b, input logic [7:0] status_b);
    send_header(id, len, resv, good);
    for (int unsigned n = 0; n < BYTES_PER_WORD * len; n++) begin
      send_byte(8'($urandom));
    end
    send_byte(drop_b);
    send_byte(status_b);
  endtask

  // mostly well-formed frames, some line noise and broken sync pairs
  task automatic send_random_traffic();
    int unsigned pick;
    int unsigned n;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      frames_sent++;
      id = ($urandom_range(0, 9) < 6) ? KNOWN_IDS[$urandom_range(0, NUM_KNOWN - 1)]
                                      : 16'($urandom);
      n = $urandom_range(0, 99);
      if (frames_sent % 20 == 7) begin
        // long enough to wrap the buffer index
        len = 16'($urandom_range(256, 270));
      end else if (n < 75) begin
        len = 16'($urandom_range(0, 6));
      end else begin
        len = 16'($urandom_range(7, 40));
      end
      b = ($urandom_range(0, 4) == 0) ? sb.sync_lo : 8'($urandom);
      send_frame(id, len, 16'($urandom), $urandom_range(0, 3) != 0, 8'($urandom), b);
    end else if (pick < 85) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_byte(($urandom_range(0, 2) == 0) ? sb.sync_lo : 8'($urandom));
      end
    end else begin
      // first sync byte followed by a wrong second one
      do begin
        b = ($urandom_range(0, 1) == 0) ? sb.sync_lo : 8'($urandom);
      end while (b == sb.sync_hi);
      send_byte(sb.sync_lo);
      send_byte(b);
    end
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    while (sb.expected_res.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2) @(posedge clk_i);
  endtask

  // both sync registers, back to back, while the block is idle
  task automatic load_sync(input logic [7:0] lo, input logic [7:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_FIRST;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SYNC_SECOND;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_sync(CFG_SYNC_FIRST, lo);
    sb.set_sync(CFG_SYNC_SECOND, hi);
    @(posedge clk_i);
  endtask

  // result side: random ready pattern plus a long hold now and then
  initial begin : result_sink
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned next_hold;
    bit          rdy;
    res_t        got;
    run_left  = 0;
    hold_left = 0;
    next_hold = 300;
    rdy       = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got.payload_valid = res_ch.payload_valid;
        got.payload_data  = res_ch.payload_data;
        got.payload_index = res_ch.payload_index;
        got.frame_status  = res_ch.frame_status;
        got.msg_type      = res_ch.msg_type;
        got.msg_id        = res_ch.msg_id;
        got.msg_words     = res_ch.msg_words;
        sb.check_result(got);
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (results_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + HOLD_EVERY;
        rdy       = 1'b0;
      end else if (run_left != 0) begin
        run_left--;
      end else if (rdy && sink_stalls_on) begin
        rdy      = 1'b0;
        run_left = $urandom_range(0, 3);
      end else begin
        rdy      = 1'b1;
        run_left = $urandom_range(0, 11);
      end
      res_ch.ready <= rdy;
    end
  end

  // main sequence
  initial begin : stimulus
    int unsigned phase_start;
    rst_ni = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SYNC_FIRST;
    cfg_wdata_i   <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // second sync mismatch is not retried as a first sync byte
    send_byte(8'h00);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    // zero-length frame, status byte looks like a sync byte
    send_frame(KNOWN_IDS[0], 16'h0000, 16'h0000, 1'b1, 8'h55, SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);

    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        pause_sender();
        drain_results();
        case (p)
          1: begin
            load_sync(8'h00, 8'h00);
          end
          2: begin
            load_sync(8'hFF, 8'h00);
          end
          3: begin
            load_sync(8'h00, 8'hFF);
          end
          default: begin
            load_sync(8'($urandom), 8'($urandom));
          end
        endcase
      end
      sink_stalls_on = (p != 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_random_traffic();
      end
    end

    // payload longer than a 16-bit byte count can hold; only its start is sent
    if (sb.rx_phase == PH_SYNC2) begin
      send_byte(~sb.sync_hi);
    end
    sender_gaps_on = 1'b0;
    send_header(KNOWN_IDS[6], 16'h8000, 16'($urandom), 1'b1);
    repeat (LONG_TAIL_BYTES) begin
      send_byte(8'($urandom));
    end
    sender_gaps_on = 1'b1;

    pause_sender();
    drain_results();
    if (sb.expected_res.size() != 0) begin
      sb.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               sb.expected_res.size());
    end
    if (sb.errors == 0) begin
      $display("** binary_frame_receiver_top: PASSED **");
    end else begin
      $display("** binary_frame_receiver_top: FAILED **");
    end
    $finish;
  end

  // hard stop
  initial begin : watchdog
    #30ms;
    $display("** binary_frame_receiver_top: FAILED **");
    $finish;
  end

endmodule
